[sv/hmi_pkg.sv]
`timescale 1ns / 1ps

package hmi_pkg;

	localparam int FIELD_SIZE_DEF = 1024;
	localparam int POS_MAX        = 8388607;
	localparam int CORDIC_ITERS   = 14;
	localparam int CORDIC_X0      = 9949;

	// Division by 1000 is a shift by 3 and a division by 125. The quotient estimate is
	// (v * floor(2^37 / 125)) >> 37, which is low by at most one for v below 2^30.
	localparam logic [30:0] DIV_RECIP = 31'd1099511627;
	localparam logic [7:0]  DIV_ODD   = 8'd125;

	typedef struct packed {
		logic [15:0] speed;
		logic [23:0] heading_rate;
		logic [23:0] spin_rate;
		logic [23:0] start_x;
		logic [23:0] start_y;
		logic [15:0] start_heading;
	} cfg_t;

	typedef struct packed {
		logic        ld_x;
		logic        ld_y;
		logic        ld_head;
		logic [23:0] data;
	} load_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_MUL_SPIN,
		OP_MUL_HEAD,
		OP_MUL_COS,
		OP_MUL_SIN,
		OP_MUL_MS,
		OP_DIV_ANG,
		OP_DIV_POS,
		OP_DIV_MUL,
		OP_DIV_FIX,
		OP_UPD_SPIN,
		OP_UPD_HEAD,
		OP_COR_LOAD,
		OP_COR_STEP,
		OP_COR_FIN,
		OP_UPD_X,
		OP_UPD_Y,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [3:0] iter;
	} dp_cmd_t;

	// Arctangent of 2^-i in 1/65536 turn, rounded to nearest.
	function automatic logic [13:0] atan_turn(input logic [3:0] idx);
		logic [13:0] r;
		case (idx)
			4'd0: r = 14'd8192;
			4'd1: r = 14'd4836;
			4'd2: r = 14'd2555;
			4'd3: r = 14'd1297;
			4'd4: r = 14'd651;
			4'd5: r = 14'd326;
			4'd6: r = 14'd163;
			4'd7: r = 14'd81;
			4'd8: r = 14'd41;
			4'd9: r = 14'd20;
			4'd10: r = 14'd10;
			4'd11: r = 14'd5;
			4'd12: r = 14'd3;
			4'd13: r = 14'd1;
			default: r = 14'd0;
		endcase
		return r;
	endfunction

endpackage

[sv/heading_motion_integrator_wrap.sv]
// Dead-reckoning integrator on a square field with wrapping edges. Each input beat carries
// the milliseconds elapsed since the previous tick; the block advances the model spin angle
// and the travel heading by rate times elapsed over 1000, takes the cosine and sine of the
// new heading with a 14-iteration CORDIC, moves the position by speed times those values,
// wraps each axis that leaves the field, and returns one result beat per tick. A new input
// beat is taken only once the previous tick has reached the result register; each tick runs
// the CORDIC steps and, for each of the two angles and the two axes, the multiplies, the
// reciprocal division by 1000 with its correction step, and the update.
// The result register lets the next tick start while a result waits to be taken. Writing a
// start register reloads that position or heading at once; configure only while idle.
`timescale 1ns / 1ps

module heading_motion_integrator_wrap #(
	parameter int FIELD_SIZE = hmi_pkg::FIELD_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] elapsed_ms, [15:10] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [23:0] x_pos, [47:24] y_pos, [63:48] heading_out,
	                               // [79:64] model_angle_out
	output logic [1:0]  m_tuser,   // [0] wrapped_x, [1] wrapped_y
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hmi_pkg::*;

	cfg_t        cfg;
	load_t       ld;
	dp_cmd_t     cmd;
	logic [23:0] x_pos;
	logic [23:0] y_pos;
	logic [15:0] heading_out;
	logic [15:0] model_angle_out;
	logic        wrapped_x;
	logic        wrapped_y;

	assign pready = 1'b1;

	hmi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg),
		.ld      (ld)
	);

	hmi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	hmi_datapath #(
		.FIELD_SIZE (FIELD_SIZE)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.elapsed_ms      (s_tdata[9:0]),
		.cfg             (cfg),
		.ld              (ld),
		.x_pos           (x_pos),
		.y_pos           (y_pos),
		.heading_out     (heading_out),
		.model_angle_out (model_angle_out),
		.wrapped_x       (wrapped_x),
		.wrapped_y       (wrapped_y)
	);

	assign m_tdata = {model_angle_out, heading_out, y_pos, x_pos};
	assign m_tuser = {wrapped_y, wrapped_x};

endmodule

[sv/hmi_regs.sv]
`timescale 1ns / 1ps

module hmi_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output hmi_pkg::cfg_t      cfg,
	output hmi_pkg::load_t     ld
);
	import hmi_pkg::*;

	localparam logic [2:0] REG_SPEED  = 3'd0;
	localparam logic [2:0] REG_HRATE  = 3'd1;
	localparam logic [2:0] REG_SRATE  = 3'd2;
	localparam logic [2:0] REG_STARTX = 3'd3;
	localparam logic [2:0] REG_STARTY = 3'd4;
	localparam logic [2:0] REG_STARTH = 3'd5;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign wr_en = psel & penable & pwrite;
	assign idx   = paddr[4:2];
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SPEED:  cfg_q.speed         <= pwdata[15:0];
				REG_HRATE:  cfg_q.heading_rate  <= pwdata[23:0];
				REG_SRATE:  cfg_q.spin_rate     <= pwdata[23:0];
				REG_STARTX: cfg_q.start_x       <= pwdata[23:0];
				REG_STARTY: cfg_q.start_y       <= pwdata[23:0];
				REG_STARTH: cfg_q.start_heading <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ld.ld_x    = wr_en && (idx == REG_STARTX);
		ld.ld_y    = wr_en && (idx == REG_STARTY);
		ld.ld_head = wr_en && (idx == REG_STARTH);
		ld.data    = pwdata[23:0];
	end

	always_comb begin
		case (idx)
			REG_SPEED:  prdata = {16'd0, cfg_q.speed};
			REG_HRATE:  prdata = {8'd0, cfg_q.heading_rate};
			REG_SRATE:  prdata = {8'd0, cfg_q.spin_rate};
			REG_STARTX: prdata = {8'd0, cfg_q.start_x};
			REG_STARTY: prdata = {8'd0, cfg_q.start_y};
			REG_STARTH: prdata = {16'd0, cfg_q.start_heading};
			default:    prdata = 32'd0;
		endcase
	end

endmodule

[sv/hmi_ctrl.sv]
`timescale 1ns / 1ps

module hmi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             m_tready,
	output logic             m_tvalid,
	output hmi_pkg::dp_cmd_t cmd
);
	import hmi_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_MUL_S, S_LDV_S, S_DIV_S, S_FIX_S, S_UPD_S,
		S_MUL_H, S_LDV_H, S_DIV_H, S_FIX_H, S_UPD_H,
		S_COR_LD, S_COR, S_COR_FIN,
		S_MUL_X, S_MS_X, S_LDV_X, S_DIV_X, S_FIX_X, S_UPD_X,
		S_MUL_Y, S_MS_Y, S_LDV_Y, S_DIV_Y, S_FIX_Y, S_UPD_Y,
		S_OUT
	} state_t;

	localparam logic [4:0] COR_LAST = 5'(CORDIC_ITERS - 1);

	state_t     state_q;
	logic [4:0] cnt_q;
	logic       m_tvalid_q;
	logic       out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_MUL_S;
				S_MUL_S: state_q <= S_LDV_S;
				S_LDV_S: state_q <= S_DIV_S;
				S_DIV_S: state_q <= S_FIX_S;
				S_FIX_S: state_q <= S_UPD_S;
				S_UPD_S: state_q <= S_MUL_H;
				S_MUL_H: state_q <= S_LDV_H;
				S_LDV_H: state_q <= S_DIV_H;
				S_DIV_H: state_q <= S_FIX_H;
				S_FIX_H: state_q <= S_UPD_H;
				S_UPD_H: state_q <= S_COR_LD;
				S_COR_LD: begin
					cnt_q   <= '0;
					state_q <= S_COR;
				end
				S_COR: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == COR_LAST) state_q <= S_COR_FIN;
				end
				S_COR_FIN: state_q <= S_MUL_X;
				S_MUL_X: state_q <= S_MS_X;
				S_MS_X: state_q <= S_LDV_X;
				S_LDV_X: state_q <= S_DIV_X;
				S_DIV_X: state_q <= S_FIX_X;
				S_FIX_X: state_q <= S_UPD_X;
				S_UPD_X: state_q <= S_MUL_Y;
				S_MUL_Y: state_q <= S_MS_Y;
				S_MS_Y: state_q <= S_LDV_Y;
				S_LDV_Y: state_q <= S_DIV_Y;
				S_DIV_Y: state_q <= S_FIX_Y;
				S_FIX_Y: state_q <= S_UPD_Y;
				S_UPD_Y: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.iter = cnt_q[3:0];
		case (state_q)
			S_IDLE:    cmd.op = s_tvalid ? OP_CAPTURE : OP_NOP;
			S_MUL_S:   cmd.op = OP_MUL_SPIN;
			S_MUL_H:   cmd.op = OP_MUL_HEAD;
			S_LDV_S,
			S_LDV_H:   cmd.op = OP_DIV_ANG;
			S_DIV_S,
			S_DIV_H,
			S_DIV_X,
			S_DIV_Y:   cmd.op = OP_DIV_MUL;
			S_FIX_S,
			S_FIX_H,
			S_FIX_X,
			S_FIX_Y:   cmd.op = OP_DIV_FIX;
			S_UPD_S:   cmd.op = OP_UPD_SPIN;
			S_UPD_H:   cmd.op = OP_UPD_HEAD;
			S_COR_LD:  cmd.op = OP_COR_LOAD;
			S_COR:     cmd.op = OP_COR_STEP;
			S_COR_FIN: cmd.op = OP_COR_FIN;
			S_MUL_X:   cmd.op = OP_MUL_COS;
			S_MUL_Y:   cmd.op = OP_MUL_SIN;
			S_MS_X,
			S_MS_Y:    cmd.op = OP_MUL_MS;
			S_LDV_X,
			S_LDV_Y:   cmd.op = OP_DIV_POS;
			S_UPD_X:   cmd.op = OP_UPD_X;
			S_UPD_Y:   cmd.op = OP_UPD_Y;
			S_OUT:     cmd.op = out_free ? OP_OUT_LOAD : OP_NOP;
			default:   cmd.op = OP_NOP;
		endcase
	end

endmodule

[sv/hmi_datapath.sv]
`timescale 1ns / 1ps

module hmi_datapath #(
	parameter int FIELD_SIZE = hmi_pkg::FIELD_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hmi_pkg::dp_cmd_t cmd,
	input  logic [9:0]       elapsed_ms,
	input  hmi_pkg::cfg_t    cfg,
	input  hmi_pkg::load_t   ld,
	output logic [23:0]      x_pos,
	output logic [23:0]      y_pos,
	output logic [15:0]      heading_out,
	output logic [15:0]      model_angle_out,
	output logic             wrapped_x,
	output logic             wrapped_y
);
	import hmi_pkg::*;

	localparam int HALF   = FIELD_SIZE * 128;
	localparam int HI_INT = (HALF > POS_MAX) ? POS_MAX : HALF;
	localparam logic signed [24:0] LIM_LO = -25'(HALF);
	localparam logic signed [24:0] LIM_HI = 25'(HI_INT);

	logic [9:0]          ms_q;
	logic signed [41:0]  prod_q;
	logic                neg_q;
	logic [29:0]         dv_q;
	logic [17:0]         quo_q;
	logic [23:0]         x_q;
	logic [23:0]         y_q;
	logic [15:0]         head_q;
	logic [15:0]         spin_q;
	logic                wx_q;
	logic                wy_q;
	logic signed [17:0]  cx_q;
	logic signed [17:0]  cy_q;
	logic signed [15:0]  cz_q;
	logic signed [16:0]  cos_q;
	logic signed [16:0]  sin_q;
	logic [23:0]         ox_q;
	logic [23:0]         oy_q;
	logic [15:0]         oh_q;
	logic [15:0]         om_q;
	logic                owx_q;
	logic                owy_q;

	logic signed [33:0]  mul_a;
	logic signed [16:0]  mul_b;
	logic signed [50:0]  mul_p;
	logic [41:0]         mag;
	logic [60:0]         rec_p;
	logic [7:0]          rem8;
	logic                fix_up;
	logic [15:0]         ang_delta;
	logic [24:0]         pos_mag;
	logic signed [24:0]  pos_delta;
	logic [23:0]         pos_base;
	logic signed [24:0]  pos_sum;
	logic [23:0]         pos_next;
	logic                pos_wrap;
	logic signed [17:0]  cor_dx;
	logic signed [17:0]  cor_dy;
	logic signed [15:0]  cor_at;
	logic signed [17:0]  neg_cx;
	logic signed [17:0]  neg_cy;

	always_comb begin
		case (cmd.op)
			OP_MUL_SPIN: begin
				mul_a = $signed({{10{cfg.spin_rate[23]}}, cfg.spin_rate});
				mul_b = $signed({7'd0, ms_q});
			end
			OP_MUL_HEAD: begin
				mul_a = $signed({{10{cfg.heading_rate[23]}}, cfg.heading_rate});
				mul_b = $signed({7'd0, ms_q});
			end
			OP_MUL_COS: begin
				mul_a = $signed({{18{cfg.speed[15]}}, cfg.speed});
				mul_b = cos_q;
			end
			OP_MUL_SIN: begin
				mul_a = $signed({{18{cfg.speed[15]}}, cfg.speed});
				mul_b = sin_q;
			end
			OP_MUL_MS: begin
				mul_a = prod_q[33:0];
				mul_b = $signed({7'd0, ms_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign mag    = prod_q[41] ? 42'(-prod_q) : prod_q;
	assign rec_p  = {31'd0, dv_q} * {30'd0, DIV_RECIP};
	assign rem8   = dv_q[7:0] - 8'(quo_q[7:0] * DIV_ODD);
	assign fix_up = (rem8 >= DIV_ODD);

	assign ang_delta = neg_q ? (16'd0 - quo_q[15:0]) : quo_q[15:0];

	assign pos_mag   = {7'd0, quo_q};
	assign pos_delta = neg_q ? -$signed(pos_mag) : $signed(pos_mag);
	assign pos_base  = (cmd.op == OP_UPD_Y) ? y_q : x_q;
	assign pos_sum   = $signed({pos_base[23], pos_base}) + pos_delta;

	always_comb begin
		if (pos_sum < LIM_LO) begin
			pos_next = LIM_HI[23:0];
			pos_wrap = 1'b1;
		end else if (pos_sum > LIM_HI) begin
			pos_next = LIM_LO[23:0];
			pos_wrap = 1'b1;
		end else begin
			pos_next = pos_sum[23:0];
			pos_wrap = 1'b0;
		end
	end

	assign cor_dx = cy_q >>> cmd.iter;
	assign cor_dy = cx_q >>> cmd.iter;
	assign cor_at = $signed({2'd0, atan_turn(cmd.iter)});
	assign neg_cx = -cx_q;
	assign neg_cy = -cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			head_q <= '0;
			spin_q <= '0;
		end else begin
			if (ld.ld_x) x_q <= ld.data;
			else if (cmd.op == OP_UPD_X) x_q <= pos_next;
			if (ld.ld_y) y_q <= ld.data;
			else if (cmd.op == OP_UPD_Y) y_q <= pos_next;
			if (ld.ld_head) head_q <= ld.data[15:0];
			else if (cmd.op == OP_UPD_HEAD) head_q <= head_q + ang_delta;
			if (cmd.op == OP_UPD_SPIN) spin_q <= spin_q + ang_delta;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: ms_q <= elapsed_ms;
			OP_MUL_SPIN,
			OP_MUL_HEAD,
			OP_MUL_COS,
			OP_MUL_SIN,
			OP_MUL_MS: prod_q <= mul_p[41:0];
			OP_DIV_ANG: begin
				neg_q <= prod_q[41];
				dv_q  <= mag[32:3];
			end
			OP_DIV_POS: begin
				neg_q <= prod_q[41];
				dv_q  <= {6'd0, mag[40:17]};
			end
			OP_DIV_MUL: quo_q <= rec_p[54:37];
			OP_DIV_FIX: quo_q <= quo_q + 18'(fix_up);
			OP_COR_LOAD: begin
				cx_q <= 18'(CORDIC_X0);
				cy_q <= '0;
				cz_q <= $signed({2'b00, head_q[13:0]});
			end
			OP_COR_STEP: begin
				if (!cz_q[15]) begin
					cx_q <= cx_q - cor_dx;
					cy_q <= cy_q + cor_dy;
					cz_q <= cz_q - cor_at;
				end else begin
					cx_q <= cx_q + cor_dx;
					cy_q <= cy_q - cor_dy;
					cz_q <= cz_q + cor_at;
				end
			end
			OP_COR_FIN: begin
				case (head_q[15:14])
					2'd0: begin
						cos_q <= cx_q[16:0];
						sin_q <= cy_q[16:0];
					end
					2'd1: begin
						cos_q <= neg_cy[16:0];
						sin_q <= cx_q[16:0];
					end
					2'd2: begin
						cos_q <= neg_cx[16:0];
						sin_q <= neg_cy[16:0];
					end
					default: begin
						cos_q <= cy_q[16:0];
						sin_q <= neg_cx[16:0];
					end
				endcase
			end
			OP_UPD_X: wx_q <= pos_wrap;
			OP_UPD_Y: wy_q <= pos_wrap;
			OP_OUT_LOAD: begin
				ox_q  <= x_q;
				oy_q  <= y_q;
				oh_q  <= head_q;
				om_q  <= spin_q;
				owx_q <= wx_q;
				owy_q <= wy_q;
			end
			default: ;
		endcase
	end

	assign x_pos           = ox_q;
	assign y_pos           = oy_q;
	assign heading_out     = oh_q;
	assign model_angle_out = om_q;
	assign wrapped_x       = owx_q;
	assign wrapped_y       = owy_q;

endmodule
